@@ design/hse_pkg.sv @@
// hse_pkg: shared types and constants of the heap sort engine.
// Used by heap_sort_engine; depends on nothing else.
`default_nettype none

package hse_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register indexes on the configuration port
    localparam logic REG_BUILD_METHOD = 1'b0;
    localparam logic REG_EMIT_LAYOUT  = 1'b1;

    // build methods
    localparam logic BUILD_SIFT_DOWN = 1'b0;
    localparam logic BUILD_SIFT_UP   = 1'b1;

    // result phases
    localparam logic PHASE_LAYOUT = 1'b0;
    localparam logic PHASE_SORTED = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_BU_NEXT,
        ST_BU_LD,
        ST_TD_NEXT,
        ST_TD_LD,
        ST_SU,
        ST_SU_W,
        ST_SD_L,
        ST_SD_LW,
        ST_SD_RW,
        ST_SD_DEC,
        ST_SO_NEXT,
        ST_SO_R0,
        ST_SO_RL,
        ST_OUT_RD,
        ST_OUT_W
    } state_t;

    // who called the sift-down sequence
    typedef enum logic {
        SD_BUILD,
        SD_SORT
    } sd_mode_t;

endpackage

`default_nettype wire

@@ design/heap_sort_engine.sv @@
// heap_sort_engine: heapsort of a set of signed 32-bit values held in one
// synchronous element memory. Depends on hse_pkg.
`default_nettype none

// Values are loaded one transaction per cycle into the element memory until a
// transaction with s_last_in arrives; values beyond CAPACITY are dropped and
// m_overflow is set on every result of that run. The heap is then built
// (bottom-up sift-down or top-down sift-up, per build_method), optionally
// emitted as phase 0, then sorted in place and emitted ascending as phase 1,
// with m_last_out on the largest element. All work goes through one memory
// read port and one write port with registered read data: a sift-down step
// reads the left and, if present, the right child and then writes the hole, a
// sift-up step reads the parent and then writes, and each result is read and
// then offered, holding while the output register is still full. s_ready is
// high only while loading. Registers: 0x0 build_method (bit 0), 0x4
// emit_heap_layout (bit 0, resets to 1).
module heap_sort_engine #(
    parameter int CAPACITY = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    // configuration
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [hse_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire signed [31:0]           s_value,
    input  wire                         s_last_in,
    // result channel
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic signed [31:0]          m_element,
    output logic                        m_phase,
    output logic                        m_overflow,
    output logic                        m_last_out
);
    import hse_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHW   = IDX_W + 1;

    // ---------------- configuration registers ----------------
    logic build_method_reg;
    logic emit_layout_reg;
    logic cfg_wr;
    logic cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            build_method_reg <= BUILD_SIFT_DOWN;
            emit_layout_reg  <= 1'b1;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (cfg_sel)
                REG_BUILD_METHOD: build_method_reg <= pwdata[0];
                REG_EMIT_LAYOUT:  emit_layout_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_sel)
            REG_BUILD_METHOD: prdata[0] = build_method_reg;
            REG_EMIT_LAYOUT:  prdata[0] = emit_layout_reg;
            default: ;
        endcase
    end

    // ---------------- element memory ----------------
    logic signed [31:0] mem [CAPACITY];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic signed [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // ---------------- sequencer state ----------------
    state_t             state_reg, state_next;
    sd_mode_t           mode_reg, mode_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;     // elements held
    logic [CNT_W-1:0]   hs_reg, hs_next;       // heap size for sift-down
    logic [CNT_W-1:0]   i_reg, i_next;         // outer loop index
    logic               ovf_reg, ovf_next;
    logic               phase_reg, phase_next;
    logic [IDX_W-1:0]   k_reg, k_next;         // hole position
    logic signed [31:0] x_reg, x_next;         // value being sifted
    logic [IDX_W-1:0]   big_reg, big_next;
    logic signed [31:0] bigval_reg, bigval_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] elem_reg, elem_next;
    logic               ophase_reg, ophase_next;
    logic               oovf_reg, oovf_next;
    logic               olast_reg, olast_next;

    // shared conditions
    logic             in_acc;
    logic             store_full;
    logic [CHW-1:0]   l_idx, r_idx, hs_ext;
    logic             l_in, r_in;
    logic [IDX_W-1:0] p_idx;
    logic             out_free;
    logic             out_last_idx;
    logic             build_done;

    assign s_ready      = (state_reg == ST_LOAD);
    assign in_acc       = s_valid && s_ready;
    assign store_full   = (cnt_reg == CNT_W'(CAPACITY));
    assign l_idx        = CHW'({k_reg, 1'b1});
    assign r_idx        = l_idx + CHW'(1);
    assign hs_ext       = CHW'(hs_reg);
    assign l_in         = (l_idx < hs_ext);
    assign r_in         = (r_idx < hs_ext);
    assign p_idx        = IDX_W'((k_reg - IDX_W'(1)) >> 1);
    assign out_free     = !m_valid_reg || m_ready;
    assign out_last_idx = (i_reg == cnt_reg - CNT_W'(1));
    assign build_done   = (state_reg == ST_BU_NEXT && i_reg == '0)
                       || (state_reg == ST_TD_NEXT && i_reg == cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:    if (in_acc && s_last_in) state_next = ST_START;
            ST_START:   state_next = (build_method_reg == BUILD_SIFT_UP)
                                   ? ST_TD_NEXT : ST_BU_NEXT;
            ST_BU_NEXT, ST_TD_NEXT: begin
                if (build_done) begin
                    state_next = emit_layout_reg ? ST_OUT_RD : ST_SO_NEXT;
                end else begin
                    state_next = (state_reg == ST_BU_NEXT) ? ST_BU_LD : ST_TD_LD;
                end
            end
            ST_BU_LD:   state_next = ST_SD_L;
            ST_TD_LD:   state_next = ST_SU;
            ST_SU:      state_next = (k_reg == '0) ? ST_TD_NEXT : ST_SU_W;
            ST_SU_W:    state_next = (x_reg > rdata_reg) ? ST_SU : ST_TD_NEXT;
            ST_SD_L: begin
                if (l_in) begin
                    state_next = ST_SD_LW;
                end else begin
                    state_next = (mode_reg == SD_SORT) ? ST_SO_NEXT : ST_BU_NEXT;
                end
            end
            ST_SD_LW:   state_next = r_in ? ST_SD_RW : ST_SD_DEC;
            ST_SD_RW:   state_next = ST_SD_DEC;
            ST_SD_DEC: begin
                if (big_reg == k_reg) begin
                    state_next = (mode_reg == SD_SORT) ? ST_SO_NEXT : ST_BU_NEXT;
                end else begin
                    state_next = ST_SD_L;
                end
            end
            ST_SO_NEXT: state_next = (i_reg <= CNT_W'(1)) ? ST_OUT_RD : ST_SO_R0;
            ST_SO_R0:   state_next = ST_SO_RL;
            ST_SO_RL:   state_next = ST_SD_L;
            ST_OUT_RD:  state_next = ST_OUT_W;
            ST_OUT_W: begin
                if (out_free) begin
                    if (!out_last_idx) begin
                        state_next = ST_OUT_RD;
                    end else begin
                        state_next = (phase_reg == PHASE_LAYOUT) ? ST_SO_NEXT : ST_LOAD;
                    end
                end
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        hs_next      = hs_reg;
        i_next       = i_reg;
        ovf_next     = ovf_reg;
        phase_next   = phase_reg;
        k_next       = k_reg;
        x_next       = x_reg;
        big_next     = big_reg;
        bigval_next  = bigval_reg;
        m_valid_next = m_valid_reg && !m_ready;
        elem_next    = elem_reg;
        ophase_next  = ophase_reg;
        oovf_next    = oovf_reg;
        olast_next   = olast_reg;
        mem_we       = 1'b0;
        mem_waddr    = k_reg;
        mem_wdata    = x_reg;
        mem_re       = 1'b0;
        mem_raddr    = k_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (store_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(cnt_reg);
                        mem_wdata = s_value;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_START: begin
                mode_next = SD_BUILD;
                hs_next   = cnt_reg;
                i_next    = (build_method_reg == BUILD_SIFT_UP) ? '0 : (cnt_reg >> 1);
            end
            ST_BU_NEXT, ST_TD_NEXT: begin
                if (build_done) begin
                    phase_next = PHASE_LAYOUT;
                    i_next     = emit_layout_reg ? '0 : cnt_reg;
                end else if (state_reg == ST_BU_NEXT) begin
                    i_next    = i_reg - CNT_W'(1);
                    k_next    = IDX_W'(i_reg - CNT_W'(1));
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(i_reg - CNT_W'(1));
                end else begin
                    k_next    = IDX_W'(i_reg);
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(i_reg);
                end
            end
            ST_BU_LD: x_next = rdata_reg;
            ST_TD_LD: begin
                x_next = rdata_reg;
                i_next = i_reg + CNT_W'(1);
            end
            ST_SU: begin
                if (k_reg == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = p_idx;
                end
            end
            ST_SU_W: begin
                mem_we = 1'b1;
                if (x_reg > rdata_reg) begin
                    mem_wdata = rdata_reg;
                    k_next    = p_idx;
                end
            end
            ST_SD_L: begin
                if (l_in) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(l_idx);
                end else begin
                    mem_we = 1'b1;
                end
            end
            ST_SD_LW: begin
                if (rdata_reg > x_reg) begin
                    big_next    = IDX_W'(l_idx);
                    bigval_next = rdata_reg;
                end else begin
                    big_next    = k_reg;
                    bigval_next = x_reg;
                end
                if (r_in) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(r_idx);
                end
            end
            ST_SD_RW: begin
                if (rdata_reg > bigval_reg) begin
                    big_next    = IDX_W'(r_idx);
                    bigval_next = rdata_reg;
                end
            end
            ST_SD_DEC: begin
                mem_we = 1'b1;
                if (big_reg != k_reg) begin
                    mem_wdata = bigval_reg;
                    k_next    = big_reg;
                end
            end
            ST_SO_NEXT: begin
                if (i_reg <= CNT_W'(1)) begin
                    i_next     = '0;
                    phase_next = PHASE_SORTED;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                end
            end
            ST_SO_R0: begin
                bigval_next = rdata_reg;            // current root
                mem_re      = 1'b1;
                mem_raddr   = IDX_W'(i_reg - CNT_W'(1));
            end
            ST_SO_RL: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(i_reg - CNT_W'(1));
                mem_wdata = bigval_reg;
                x_next    = rdata_reg;
                hs_next   = i_reg - CNT_W'(1);
                i_next    = i_reg - CNT_W'(1);
                k_next    = '0;
                mode_next = SD_SORT;
            end
            ST_OUT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(i_reg);
            end
            ST_OUT_W: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    elem_next    = rdata_reg;
                    ophase_next  = phase_reg;
                    oovf_next    = ovf_reg;
                    olast_next   = (phase_reg == PHASE_SORTED) && out_last_idx;
                    i_next       = i_reg + CNT_W'(1);
                    if (out_last_idx) begin
                        if (phase_reg == PHASE_LAYOUT) begin
                            i_next = cnt_reg;
                        end else begin
                            // end of run: ready for the next set
                            cnt_next = '0;
                            hs_next  = '0;
                            ovf_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            mode_reg    <= SD_BUILD;
            cnt_reg     <= '0;
            hs_reg      <= '0;
            i_reg       <= '0;
            ovf_reg     <= 1'b0;
            phase_reg   <= PHASE_LAYOUT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            cnt_reg     <= cnt_next;
            hs_reg      <= hs_next;
            i_reg       <= i_next;
            ovf_reg     <= ovf_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        x_reg      <= x_next;
        big_reg    <= big_next;
        bigval_reg <= bigval_next;
        elem_reg   <= elem_next;
        ophase_reg <= ophase_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_element  = elem_reg;
    assign m_phase    = ophase_reg;
    assign m_overflow = oovf_reg;
    assign m_last_out = olast_reg;

endmodule

`default_nettype wire

@@ sim/sort_result_checker.sv @@
// sort_result_checker: watches the register port and both streams of the heap
// sort engine, predicts every result transaction and compares it field by field.
// Depends on hse_pkg.
module sort_result_checker #(
    parameter int CAPACITY = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [hse_pkg::ADDR_W-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    input  wire                          pready,
    input  wire                          s_valid,
    input  wire                          s_ready,
    input  wire signed [31:0]            s_value,
    input  wire                          s_last_in,
    input  wire                          m_valid,
    input  wire                          m_ready,
    input  wire signed [31:0]            m_element,
    input  wire                          m_phase,
    input  wire                          m_overflow,
    input  wire                          m_last_out,
    output int                           errors,
    output int                           pending
);
    import hse_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] element;
        logic                     phase;
        logic                     overflow;
        logic                     last_out;
    } heap_word_t;

    // set being loaded and the heap built on it
    logic signed [DATA_W-1:0] held [CAPACITY];
    int  held_cnt;
    int  heap_len;
    bit  held_ovf;
    bit  cfg_build;
    bit  cfg_layout;

    heap_word_t expected_words [$];
    heap_word_t want;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic flag_error(string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic void swap_held(int i, int j);
        logic signed [DATA_W-1:0] tmp;
        tmp     = held[i];
        held[i] = held[j];
        held[j] = tmp;
    endfunction

    // strict compares: equal children leave the parent in place
    function automatic void sift_down_from(int at);
        int big;
        int lc;
        int rc;
        while (1) begin
            big = at;
            lc  = 2 * at + 1;
            rc  = 2 * at + 2;
            if (lc < heap_len && held[lc] > held[big]) big = lc;
            if (rc < heap_len && held[rc] > held[big]) big = rc;
            if (big == at) break;
            swap_held(at, big);
            at = big;
        end
    endfunction

    function automatic void push_word(logic signed [DATA_W-1:0] e, logic ph, logic lst);
        heap_word_t w;
        w.element  = e;
        w.phase    = ph;
        w.overflow = held_ovf;
        w.last_out = lst;
        expected_words.push_back(w);
    endfunction

    // one accepted input transaction; the last one of a set sorts it
    function automatic void take_value(logic signed [DATA_W-1:0] v, logic lst);
        int n;
        int k;
        int par;
        if (held_cnt < CAPACITY) begin
            held[held_cnt] = v;
            held_cnt++;
        end else begin
            held_ovf = 1'b1;
        end
        if (!lst) return;
        n = held_cnt;
        if (cfg_build == BUILD_SIFT_DOWN) begin
            heap_len = n;
            for (int i = n / 2; i > 0; i--)
                sift_down_from(i - 1);
        end else begin
            heap_len = 0;
            for (int i = 0; i < n; i++) begin
                k = i;
                heap_len++;
                while (k > 0) begin
                    par = (k - 1) / 2;
                    if (!(held[k] > held[par])) break;
                    swap_held(k, par);
                    k = par;
                end
            end
        end
        if (cfg_layout)
            for (int i = 0; i < n; i++)
                push_word(held[i], PHASE_LAYOUT, 1'b0);
        for (int i = n; i > 1; i--) begin
            swap_held(0, i - 1);
            heap_len--;
            sift_down_from(0);
        end
        for (int i = 0; i < n; i++)
            push_word(held[i], PHASE_SORTED, i + 1 == n);
        held_cnt = 0;
        heap_len = 0;
        held_ovf = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt   = 0;
            heap_len   = 0;
            held_ovf   = 1'b0;
            cfg_build  = BUILD_SIFT_DOWN;
            cfg_layout = 1'b1;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1:2] == REG_BUILD_METHOD)
                    cfg_build = pwdata[0];
                else if (paddr[ADDR_W-1:2] == REG_EMIT_LAYOUT)
                    cfg_layout = pwdata[0];
            end
            if (s_valid && s_ready)
                take_value(s_value, s_last_in);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    flag_error($sformatf("unexpected result element %0d", m_element));
                end else begin
                    want = expected_words.pop_front();
                    if (m_element !== want.element)
                        flag_error($sformatf("element %0d, want %0d", m_element,
                                             want.element));
                    if (m_phase !== want.phase)
                        flag_error($sformatf("phase %b, want %b", m_phase, want.phase));
                    if (m_overflow !== want.overflow)
                        flag_error($sformatf("overflow %b, want %b", m_overflow,
                                             want.overflow));
                    if (m_last_out !== want.last_out)
                        flag_error($sformatf("last_out %b, want %b", m_last_out,
                                             want.last_out));
                end
            end
        end
        pending <= expected_words.size();
    end

endmodule

@@ sim/heap_sort_engine_test.sv @@
// heap_sort_engine_test: stimulus and verdict for heap_sort_engine; result
// checking lives in sort_result_checker. Depends on hse_pkg and both modules.
module heap_sort_engine_test;
    import hse_pkg::*;

    localparam int CAPACITY = 32;

    // Slowest honest run: sets of up to 40 values, each set sorted and then
    // giving up to 64 results that may each wait on a stall, plus the long
    // hold-off. The limit is set well above what such a run needs.
    localparam int CYCLE_LIMIT = 600000;

    // value flavors of a generated set
    localparam int VALS_RANDOM  = 0;
    localparam int VALS_TIES    = 1;
    localparam int VALS_EXTREME = 2;
    localparam int VALS_RISING  = 3;
    localparam int VALS_FALLING = 4;

    localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    wire  [31:0]        prdata;
    wire                pready;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic signed [31:0] s_value = '0;
    logic               s_last_in = 1'b0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire signed [31:0]  m_element;
    wire                m_phase;
    wire                m_overflow;
    wire                m_last_out;

    int errors;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int hold_asks = 0;     // bumped by stimulus, served by the receiver
    int hold_served = 0;
    int hold_left = 0;
    int rx_pos = 0;
    logic [15:0] rx_mask = '1;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    heap_sort_engine #(.CAPACITY(CAPACITY)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value), .s_last_in(s_last_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_element(m_element), .m_phase(m_phase),
        .m_overflow(m_overflow), .m_last_out(m_last_out)
    );

    sort_result_checker #(.CAPACITY(CAPACITY)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value), .s_last_in(s_last_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_element(m_element), .m_phase(m_phase),
        .m_overflow(m_overflow), .m_last_out(m_last_out),
        .errors(errors), .pending(pending)
    );

    // Watchdog: a hung handshake or missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result-side backpressure. A long hold-off request takes priority;
    // otherwise m_ready follows a 16-bit mask that is redrawn every lap,
    // all ones a quarter of the time so some stretches never stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_asks != hold_served) begin
            hold_served++;
            hold_left = 1500;
            m_ready <= 1'b0;
        end else begin
            if (rx_pos == 0)
                rx_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            m_ready <= rx_mask[rx_pos];
            rx_pos = (rx_pos + 1) % 16;
        end
    end

    // Offer one input transaction and wait for it to be taken. Bursts of
    // back-to-back transactions are separated by random gaps; valid is only
    // dropped when a real gap follows, never lowered and raised in one step.
    task automatic send_value(logic signed [31:0] v, logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_value   <= v;
        s_last_in <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // One set of len values, last_in on the final one.
    task automatic send_set(int len, int flavor);
        logic signed [31:0] base;
        logic signed [31:0] v;
        base = $urandom;
        for (int i = 0; i < len; i++) begin
            case (flavor)
                VALS_TIES:    v = $signed($urandom_range(0, 6)) - 3;
                VALS_EXTREME: begin
                    case ($urandom_range(0, 5))
                        0: v = MIN_VAL;
                        1: v = MAX_VAL;
                        2: v = 0;
                        3: v = -1;
                        4: v = 1;
                        default: v = $urandom;
                    endcase
                end
                VALS_RISING:  v = base + i;
                VALS_FALLING: v = base - i;
                default:      v = $urandom;
            endcase
            send_value(v, i == len - 1);
        end
    endtask

    // Stop offering, let every expected result come back, then give the
    // block time to fall back to loading.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // setup, access, then idle with psel low, so back-to-back writes never
    // drive the bus twice in one step
    task automatic apb_write(logic idx, logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_FFFE) | val;   // upper bits are don't-care
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_regs(logic build, logic layout);
        apb_write(REG_BUILD_METHOD, build);
        apb_write(REG_EMIT_LAYOUT, layout);
    endtask

    // Register settings per random phase: both builds, layout on and off.
    logic phase_build  [5] = '{BUILD_SIFT_DOWN, BUILD_SIFT_UP, BUILD_SIFT_UP,
                               BUILD_SIFT_DOWN, BUILD_SIFT_UP};
    logic phase_layout [5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    initial begin
        int start_items;
        int len;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_regs(BUILD_SIFT_DOWN, 1'b1);

        // Directed: a one-value set, the field extremes with duplicates, a
        // three-value set of small values prone to ties, a strictly falling set and a two-value set.
        send_value(MAX_VAL, 1'b1);
        send_value(MIN_VAL, 1'b0);
        send_value(MAX_VAL, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(5, 1'b0);
        send_value(5, 1'b0);
        send_value(5, 1'b0);
        send_value(MIN_VAL, 1'b1);
        send_set(3, VALS_TIES);
        send_set(6, VALS_FALLING);
        send_set(2, VALS_RISING);

        for (int p = 0; p < 5; p++) begin
            // each phase starts from an empty pipeline: full sender pause
            wait_idle();
            program_regs(phase_build[p], phase_layout[p]);
            start_items = items_sent;

            // store-full cases: dropped values (last one dropped too),
            // and a set that exactly fills the store
            case (p)
                0: send_set(CAPACITY + 2, VALS_RANDOM);
                1: send_set(CAPACITY, VALS_EXTREME);
                2: send_set(CAPACITY + 1, VALS_TIES);
                3: send_set(CAPACITY + 8, VALS_RISING);
                default: ;
            endcase

            // long receiver hold-off while the sender keeps offering
            if (p == 1) begin
                hold_asks++;
                send_set(8, VALS_RANDOM);
                send_set(5, VALS_TIES);
            end

            while (items_sent - start_items < 60) begin
                case ($urandom_range(0, 19))
                    0:       len = CAPACITY + $urandom_range(1, 6);
                    1:       len = CAPACITY;
                    2, 3:    len = $urandom_range(11, CAPACITY - 1);
                    default: len = $urandom_range(1, 10);
                endcase
                send_set(len, $urandom_range(VALS_RANDOM, VALS_FALLING));
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
